// ===== rtl/core/bdlp_pkg.sv =====
package bdlp_pkg;

    localparam int KEY_BITS = 8;
    localparam int KEY_SHIFT = (KEY_BITS >= 8) ? 8 : KEY_BITS;
    localparam logic [15:0] KEY_FIELD_WIDE = (16'd1 << KEY_SHIFT) - 16'd1;
    localparam logic [7:0] KEY_FIELD = KEY_FIELD_WIDE[7:0];

    localparam logic [2:0] REQ_SAMPLE     = 3'd0;
    localparam logic [2:0] REQ_CONNECT    = 3'd1;
    localparam logic [2:0] REQ_DISCONNECT = 3'd2;
    localparam logic [2:0] REQ_START      = 3'd3;
    localparam logic [2:0] REQ_STOP       = 3'd4;

    localparam logic [1:0] ST_SENT          = 2'd0;
    localparam logic [1:0] ST_NOT_CONNECTED = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED     = 2'd2;

    localparam logic [2:0] CFG_KEY_MODE        = 3'd0;
    localparam logic [2:0] CFG_PIN_INVERT      = 3'd1;
    localparam logic [2:0] CFG_VALID_MASK      = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE_TICKS  = 3'd3;
    localparam logic [2:0] CFG_HEARTBEAT_TICKS = 3'd4;

    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  pressed_value;
        logic [31:0] sequence_number;
        logic [1:0]  send_status;
        logic        last_result;
    } result_t;

endpackage

// ===== rtl/core/button_debounce_lease_publisher_top.sv =====
// Debounced button / key-set publisher. Each item (sample poll, link connect,
// link disconnect, start, stop) is taken and updates the debounce, arming and
// sequence state at once; it yields zero, one or two results, which go into a
// four-entry result queue. Input items are taken every cycle while the queue
// has room for two results (in_stall rises when fewer than two slots are free),
// so the sustained rate is one item per cycle, limited only by the output side
// delivering one result per cycle. A result is registered into the queue when
// its item is taken, behind earlier results. Registers are written through the
// cfg port (always ready) and should only change while no item is in flight.
module button_debounce_lease_publisher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [7:0]  sample_value,
    input  logic [31:0] now_tick,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pressed_value,
    output logic [31:0] sequence_number,
    output logic [1:0]  send_status,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bdlp_pkg::*;

    // configuration
    logic        key_mode_reg;
    logic        pin_invert_reg;
    logic [7:0]  valid_mask_reg;
    logic [15:0] debounce_reg;
    logic [15:0] heartbeat_reg;

    // block state
    logic        running_reg, running_next;
    logic        connected_reg, connected_next;
    logic        armed_reg, armed_next;
    logic        release_seen_reg, release_seen_next;
    logic        disc_pending_reg, disc_pending_next;
    logic        cand_known_reg, cand_known_next;
    logic [7:0]  cand_value_reg, cand_value_next;
    logic [31:0] cand_since_reg, cand_since_next;
    logic        stable_known_reg, stable_known_next;
    logic [7:0]  stable_value_reg, stable_value_next;
    logic [31:0] hb_since_reg, hb_since_next;
    logic [31:0] seq_reg, seq_next;

    // result queue
    result_t     fifo_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg, count_next;

    logic        in_accept;
    logic        out_pop;
    logic        cfg_write;

    logic [7:0]  value;
    logic        reject;
    logic        ck, sk;
    logic [31:0] dt_cand, dt_hb;
    logic        hold_done, hb_due;

    logic [1:0]  n_att;
    logic [7:0]  att_val0, att_val1;
    logic        conn_att;

    logic [31:0] seq_p1, seq_p2;
    logic        exh0, exh1;
    result_t     res0, res1;
    logic [1:0]  n_push;

    assign in_accept = in_valid && !in_stall;
    assign out_pop   = out_valid && !out_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sample conditioning
    assign reject  = key_mode_reg && ((sample_value & ~(valid_mask_reg & KEY_FIELD)) != 8'd0);
    assign value   = key_mode_reg ? sample_value
                                  : {7'd0, sample_value[0] ^ pin_invert_reg};
    assign ck      = cand_known_reg && !disc_pending_reg;
    assign sk      = stable_known_reg && !disc_pending_reg;
    assign dt_cand = now_tick - cand_since_reg;
    assign dt_hb   = now_tick - hb_since_reg;
    assign hold_done = dt_cand >= {16'd0, debounce_reg};
    assign hb_due    = dt_hb >= {16'd0, heartbeat_reg};

    always_comb
    begin
        running_next      = running_reg;
        connected_next    = connected_reg;
        armed_next        = armed_reg;
        release_seen_next = release_seen_reg;
        disc_pending_next = disc_pending_reg;
        cand_known_next   = cand_known_reg;
        cand_value_next   = cand_value_reg;
        cand_since_next   = cand_since_reg;
        stable_known_next = stable_known_reg;
        stable_value_next = stable_value_reg;
        hb_since_next     = hb_since_reg;
        n_att             = 2'd0;
        att_val0          = 8'd0;
        att_val1          = 8'd0;
        conn_att          = connected_reg;

        if (in_accept)
        begin
            unique case (req_type)
                REQ_SAMPLE:
                begin
                    if (running_reg && !reject)
                    begin
                        disc_pending_next = 1'b0;
                        stable_known_next = sk;
                        cand_known_next   = 1'b1;
                        if (!ck || value != cand_value_reg)
                        begin
                            cand_value_next = value;
                            cand_since_next = now_tick;
                        end
                        else if ((!sk || stable_value_reg != cand_value_reg) && hold_done)
                        begin
                            stable_known_next = 1'b1;
                            stable_value_next = cand_value_reg;
                            if (cand_value_reg == 8'd0)
                            begin
                                release_seen_next = 1'b1;
                                armed_next        = 1'b1;
                                n_att             = 2'd1;
                            end
                            else if (armed_reg)
                            begin
                                n_att    = 2'd1;
                                att_val0 = cand_value_reg;
                            end
                        end
                        // heartbeat sees the state after the debounce step
                        if (stable_known_next && armed_next && hb_due)
                        begin
                            hb_since_next = now_tick;
                            if (n_att == 2'd0)
                            begin
                                att_val0 = stable_value_next;
                            end
                            else
                            begin
                                att_val1 = stable_value_next;
                            end
                            n_att = n_att + 2'd1;
                        end
                    end
                end
                REQ_CONNECT:
                begin
                    if (running_reg && !connected_reg)
                    begin
                        connected_next = 1'b1;
                        conn_att       = 1'b1;
                        if (release_seen_reg)
                        begin
                            armed_next = 1'b1;
                            n_att      = 2'd1;
                        end
                    end
                end
                REQ_DISCONNECT:
                begin
                    if (running_reg)
                    begin
                        connected_next    = 1'b0;
                        armed_next        = 1'b0;
                        release_seen_next = 1'b0;
                        disc_pending_next = 1'b1;
                    end
                end
                REQ_START:
                begin
                    if (!running_reg)
                    begin
                        stable_known_next = 1'b0;
                        cand_known_next   = 1'b0;
                        armed_next        = 1'b0;
                        release_seen_next = 1'b0;
                        disc_pending_next = 1'b0;
                        hb_since_next     = now_tick;
                        running_next      = 1'b1;
                    end
                end
                REQ_STOP:
                begin
                    if (running_reg)
                    begin
                        n_att          = 2'd1;
                        connected_next = 1'b0;
                        running_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequence numbers for up to two attempts, counter saturates at its maximum
    assign seq_p1 = seq_reg + 32'd1;
    assign seq_p2 = seq_reg + 32'd2;
    assign exh0   = seq_reg == SEQ_MAX;
    assign exh1   = exh0 || (seq_p1 == SEQ_MAX);

    always_comb
    begin
        res0.pressed_value   = att_val0;
        res0.sequence_number = exh0 ? 32'd0 : seq_p1;
        res0.send_status     = exh0 ? ST_EXHAUSTED
                                    : (conn_att ? ST_SENT : ST_NOT_CONNECTED);
        res0.last_result     = n_att == 2'd1;
        res1.pressed_value   = att_val1;
        res1.sequence_number = exh1 ? 32'd0 : seq_p2;
        res1.send_status     = exh1 ? ST_EXHAUSTED
                                    : (conn_att ? ST_SENT : ST_NOT_CONNECTED);
        res1.last_result     = 1'b1;
        n_push               = n_att;

        if (in_accept && req_type == REQ_START && !running_reg)
        begin
            seq_next = 32'd0;
        end
        else
        begin
            unique case (n_att)
                2'd1:    seq_next = exh0 ? SEQ_MAX : seq_p1;
                2'd2:    seq_next = exh1 ? SEQ_MAX : seq_p2;
                default: seq_next = seq_reg;
            endcase
        end
    end

    assign count_next = count_reg + {1'b0, n_push} - {2'd0, out_pop};
    assign in_stall   = count_reg > 3'd2;

    assign out_valid       = count_reg != 3'd0;
    assign pressed_value   = fifo_reg[rd_ptr_reg].pressed_value;
    assign sequence_number = fifo_reg[rd_ptr_reg].sequence_number;
    assign send_status     = fifo_reg[rd_ptr_reg].send_status;
    assign last_result     = fifo_reg[rd_ptr_reg].last_result;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg     <= 1'b0;
            pin_invert_reg   <= 1'b0;
            valid_mask_reg   <= 8'd255;
            debounce_reg     <= 16'd30;
            heartbeat_reg    <= 16'd1000;
            running_reg      <= 1'b0;
            connected_reg    <= 1'b0;
            armed_reg        <= 1'b0;
            release_seen_reg <= 1'b0;
            disc_pending_reg <= 1'b0;
            cand_known_reg   <= 1'b0;
            cand_value_reg   <= 8'd0;
            cand_since_reg   <= 32'd0;
            stable_known_reg <= 1'b0;
            stable_value_reg <= 8'd0;
            hb_since_reg     <= 32'd0;
            seq_reg          <= 32'd0;
            wr_ptr_reg       <= 2'd0;
            rd_ptr_reg       <= 2'd0;
            count_reg        <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_KEY_MODE:        key_mode_reg   <= cfg_data[0];
                    CFG_PIN_INVERT:      pin_invert_reg <= cfg_data[0];
                    CFG_VALID_MASK:      valid_mask_reg <= cfg_data[7:0];
                    CFG_DEBOUNCE_TICKS:  debounce_reg   <= cfg_data[15:0];
                    CFG_HEARTBEAT_TICKS: heartbeat_reg  <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            running_reg      <= running_next;
            connected_reg    <= connected_next;
            armed_reg        <= armed_next;
            release_seen_reg <= release_seen_next;
            disc_pending_reg <= disc_pending_next;
            cand_known_reg   <= cand_known_next;
            cand_value_reg   <= cand_value_next;
            cand_since_reg   <= cand_since_next;
            stable_known_reg <= stable_known_next;
            stable_value_reg <= stable_value_next;
            hb_since_reg     <= hb_since_next;
            seq_reg          <= seq_next;
            wr_ptr_reg       <= wr_ptr_reg + n_push;
            rd_ptr_reg       <= rd_ptr_reg + {1'b0, out_pop};
            count_reg        <= count_next;
        end
    end

endmodule

// ===== rtl/core/bdlp_checker.sv =====
module bdlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  pressed_value,
    input logic [31:0] sequence_number,
    input logic [1:0]  send_status,
    input logic        last_result,
    input logic        cfg_ready
);
    import bdlp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pressed_value)
            && $stable(sequence_number) && $stable(send_status) && $stable(last_result))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> send_status == ST_SENT || send_status == ST_NOT_CONNECTED
            || send_status == ST_EXHAUSTED)
        else $error("bad send status");

    // exhausted attempts carry no number, others always a non-zero one
    a_exh_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_status == ST_EXHAUSTED |-> sequence_number == 32'd0)
        else $error("exhausted item with sequence number");

    a_used_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_status != ST_EXHAUSTED |-> sequence_number != 32'd0)
        else $error("sent item with zero sequence number");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind button_debounce_lease_publisher_top bdlp_checker u_bdlp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pressed_value   (pressed_value),
    .sequence_number (sequence_number),
    .send_status     (send_status),
    .last_result     (last_result),
    .cfg_ready       (cfg_ready)
);
